>>> rtl/ssd3_pkg.sv
// ----------------------------------------------------------------------------
// ssd3_pkg
// Widths, vector types and small arithmetic helpers for the 3D
// segment-to-segment distance unit.
// ----------------------------------------------------------------------------
package ssd3_pkg;

    localparam int COORD_W     = 19;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int CRS_W       = 2 * DIFF_W;
    localparam int DOT_W       = 2 * DIFF_W + 1;
    localparam int OP_W        = DOT_W + 1;
    localparam int OP_HALF     = OP_W / 2;
    localparam int PROD_W      = 2 * OP_W;
    localparam int CRS_HALF    = CRS_W / 2;
    localparam int DEN_W       = 2 * CRS_W;
    localparam int RN_W        = DIFF_W + CRS_W + 2;
    localparam int RN_MAG_W    = RN_W - 2;
    localparam int RN_HALF     = RN_MAG_W / 2;
    localparam int NUM_W       = 2 * RN_MAG_W;
    localparam int DIST_W      = 20;
    localparam int ROOT_STAGES = DIST_W;
    localparam int SQ_W        = NUM_W + 2;
    localparam int RM_W        = DEN_W + DIST_W;
    localparam int N_PT        = 4;
    localparam int N_PROD      = 8;

    // floor(2*sqrt(3)*1000*2^8)
    localparam logic [DIST_W-1:0] DIST_CAP = DIST_W'(886810);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DOT_W-1:0]   dot_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } cvec_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } dvec_t;

    typedef struct packed {
        logic signed [CRS_W-1:0] x;
        logic signed [CRS_W-1:0] y;
        logic signed [CRS_W-1:0] z;
    } xvec_t;

    typedef enum logic [1:0] {
        PT_START = 2'd0,
        PT_END   = 2'd1,
        PT_MID   = 2'd2
    } pt_sel_t;

    function automatic dvec_t vsub(cvec_t a, cvec_t b);
        dvec_t d;
        d.x = DIFF_W'(a.x) - DIFF_W'(b.x);
        d.y = DIFF_W'(a.y) - DIFF_W'(b.y);
        d.z = DIFF_W'(a.z) - DIFF_W'(b.z);
        return d;
    endfunction

    function automatic dot_t dot3(dvec_t u, dvec_t v);
        logic signed [CRS_W-1:0] px;
        logic signed [CRS_W-1:0] py;
        logic signed [CRS_W-1:0] pz;
        px = u.x * v.x;
        py = u.y * v.y;
        pz = u.z * v.z;
        return DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
    endfunction

    function automatic xvec_t cross3(dvec_t u, dvec_t v);
        logic signed [CRS_W-1:0] p1;
        logic signed [CRS_W-1:0] p2;
        xvec_t c;
        p1 = u.y * v.z;
        p2 = u.z * v.y;
        c.x = p1 - p2;
        p1 = u.z * v.x;
        p2 = u.x * v.z;
        c.y = p1 - p2;
        p1 = u.x * v.y;
        p2 = u.y * v.x;
        c.z = p1 - p2;
        return c;
    endfunction

    function automatic logic signed [CRS_W-1:0] xsel(xvec_t v, logic [1:0] i);
        logic signed [CRS_W-1:0] r;
        case (i)
            2'd0:    r = v.x;
            2'd1:    r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

    function automatic logic signed [DIFF_W-1:0] dsel(dvec_t v, logic [1:0] i);
        logic signed [DIFF_W-1:0] r;
        case (i)
            2'd0:    r = v.x;
            2'd1:    r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

    function automatic logic [CRS_W-1:0] mag_crs(logic signed [CRS_W-1:0] v);
        logic [CRS_W-1:0] u;
        u = v;
        return v[CRS_W-1] ? (~u + CRS_W'(1)) : u;
    endfunction

    function automatic logic [OP_W-1:0] mag_op(logic signed [OP_W-1:0] v);
        logic [OP_W-1:0] u;
        u = v;
        return v[OP_W-1] ? (~u + OP_W'(1)) : u;
    endfunction

    function automatic logic [RN_W-1:0] mag_rn(logic signed [RN_W-1:0] v);
        logic [RN_W-1:0] u;
        u = v;
        return v[RN_W-1] ? (~u + RN_W'(1)) : u;
    endfunction

endpackage

>>> rtl/segment_segment_distance_3d_unit.sv
// ----------------------------------------------------------------------------
// segment_segment_distance_3d_unit
// Least distance between two 3D segments in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one segment pair per cycle unless the output stalls and returns the
// floor of the exact least distance: six stages form the endpoint
// projections and the interior candidate as exact numerator/denominator
// pairs, twenty stages take one root bit each for all five candidates in
// parallel, and a last stage keeps the minimum and saturates it. A stall on
// the output freezes the whole pipeline; no item is dropped or repeated.
module segment_segment_distance_3d_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  ssd3_pkg::coord_t             seg_a_start_x,
    input  ssd3_pkg::coord_t             seg_a_start_y,
    input  ssd3_pkg::coord_t             seg_a_start_z,
    input  ssd3_pkg::coord_t             seg_a_end_x,
    input  ssd3_pkg::coord_t             seg_a_end_y,
    input  ssd3_pkg::coord_t             seg_a_end_z,
    input  ssd3_pkg::coord_t             seg_b_start_x,
    input  ssd3_pkg::coord_t             seg_b_start_y,
    input  ssd3_pkg::coord_t             seg_b_start_z,
    input  ssd3_pkg::coord_t             seg_b_end_x,
    input  ssd3_pkg::coord_t             seg_b_end_y,
    input  ssd3_pkg::coord_t             seg_b_end_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ssd3_pkg::DIST_W-1:0]  distance
);
    import ssd3_pkg::*;

    localparam int PRE_STAGES = 6;
    localparam int PIPE_DEPTH = PRE_STAGES + ROOT_STAGES + 1;

    logic                  advance;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [DIST_W-1:0]     dist_reg;

    cvec_t a0, a1, b0, b1;
    cvec_t pp [N_PT];
    cvec_t pq0 [N_PT];
    cvec_t pq1 [N_PT];

    // stage 1
    dvec_t pw1_reg [N_PT];
    dvec_t pe1_reg [N_PT];
    dvec_t pb1_reg [N_PT];
    dvec_t ia1_reg, ib1_reg, ir1_reg;

    // stage 2
    dot_t  bb2_reg [N_PT];
    dot_t  wb2_reg [N_PT];
    dot_t  ww2_reg [N_PT];
    dot_t  ee2_reg [N_PT];
    xvec_t c2_reg  [N_PT];
    dot_t  iaa2_reg, ibb2_reg, iab2_reg, iar2_reg, ibr2_reg;
    xvec_t n2_reg;
    dvec_t r2_reg;

    // stage 3
    pt_sel_t                  sel3_reg [N_PT];
    logic [CRS_W-1:0]         ww3_reg  [N_PT];
    logic [CRS_W-1:0]         ee3_reg  [N_PT];
    logic [CRS_W-1:0]         bb3_reg  [N_PT];
    logic [CRS_W-1:0]         chh3_reg [N_PT][3];
    logic [CRS_W-1:0]         chl3_reg [N_PT][3];
    logic [CRS_W-1:0]         cll3_reg [N_PT][3];
    logic signed [OP_W-1:0]   op3_reg  [2*N_PROD];
    logic                     nz3_reg;
    logic [CRS_W-1:0]         nhh3_reg [3];
    logic [CRS_W-1:0]         nhl3_reg [3];
    logic [CRS_W-1:0]         nll3_reg [3];
    logic signed [CRS_W-1:0]  rnh3_reg [3];
    logic signed [CRS_W:0]    rnl3_reg [3];

    // stage 4
    logic [NUM_W-1:0]         pn4_reg [N_PT];
    logic [DEN_W-1:0]         pm4_reg [N_PT];
    logic [OP_W-1:0]          qhh4_reg [N_PROD];
    logic [OP_W-1:0]          qhl4_reg [N_PROD];
    logic [OP_W-1:0]          qlh4_reg [N_PROD];
    logic [OP_W-1:0]          qll4_reg [N_PROD];
    logic                     qneg4_reg [N_PROD];
    logic                     nz4_reg;
    logic [DEN_W-1:0]         im4_reg;
    logic signed [RN_W-1:0]   rn4_reg;

    // stage 5
    logic [NUM_W-1:0]         pn5_reg [N_PT];
    logic [DEN_W-1:0]         pm5_reg [N_PT];
    logic signed [PROD_W-1:0] prod5_reg [N_PROD];
    logic                     nz5_reg;
    logic [DEN_W-1:0]         im5_reg;
    logic [RN_MAG_W-1:0]      rhh5_reg, rhl5_reg, rll5_reg;

    // stage 6
    logic [NUM_W-1:0]         pn6_reg [N_PT];
    logic [DEN_W-1:0]         pm6_reg [N_PT];
    logic                     ok6_reg;
    logic [DEN_W-1:0]         im6_reg;
    logic [NUM_W-1:0]         in6_reg;

    logic [ROOT_STAGES-1:0]   okp_reg;
    logic [DIST_W-1:0]        rt [N_PT+1];
    logic [DIST_W-1:0]        best;

    assign advance  = !(vld_reg[PIPE_DEPTH-1] && out_stall);
    assign in_stall = !advance;

    assign a0 = {seg_a_start_x, seg_a_start_y, seg_a_start_z};
    assign a1 = {seg_a_end_x, seg_a_end_y, seg_a_end_z};
    assign b0 = {seg_b_start_x, seg_b_start_y, seg_b_start_z};
    assign b1 = {seg_b_end_x, seg_b_end_y, seg_b_end_z};

    // each endpoint against the other segment
    assign pp[0] = a0;  assign pq0[0] = b0;  assign pq1[0] = b1;
    assign pp[1] = a1;  assign pq0[1] = b0;  assign pq1[1] = b1;
    assign pp[2] = b0;  assign pq0[2] = a0;  assign pq1[2] = a1;
    assign pp[3] = b1;  assign pq0[3] = a0;  assign pq1[3] = a1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // stage 1: difference vectors
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int u = 0; u < N_PT; u++)
            begin
                pw1_reg[u] <= vsub(pp[u], pq0[u]);
                pe1_reg[u] <= vsub(pp[u], pq1[u]);
                pb1_reg[u] <= vsub(pq1[u], pq0[u]);
            end
            ia1_reg <= vsub(a1, a0);
            ib1_reg <= vsub(b1, b0);
            ir1_reg <= vsub(a0, b0);
        end
    end

    // stage 2: dot and cross products
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int u = 0; u < N_PT; u++)
            begin
                bb2_reg[u] <= dot3(pb1_reg[u], pb1_reg[u]);
                wb2_reg[u] <= dot3(pw1_reg[u], pb1_reg[u]);
                ww2_reg[u] <= dot3(pw1_reg[u], pw1_reg[u]);
                ee2_reg[u] <= dot3(pe1_reg[u], pe1_reg[u]);
                c2_reg[u]  <= cross3(pw1_reg[u], pb1_reg[u]);
            end
            iaa2_reg <= dot3(ia1_reg, ia1_reg);
            ibb2_reg <= dot3(ib1_reg, ib1_reg);
            iab2_reg <= dot3(ia1_reg, ib1_reg);
            iar2_reg <= dot3(ia1_reg, ir1_reg);
            ibr2_reg <= dot3(ib1_reg, ir1_reg);
            n2_reg   <= cross3(ia1_reg, ib1_reg);
            r2_reg   <= ir1_reg;
        end
    end

    // stage 3: case select, partial products, interior test operands
    always_ff @(posedge clk)
    begin
        logic [CRS_W-1:0]        m;
        logic signed [CRS_W-1:0] nc;
        if (advance)
        begin
            for (int u = 0; u < N_PT; u++)
            begin
                if (bb2_reg[u] == '0 || wb2_reg[u][DOT_W-1] || wb2_reg[u] == '0)
                    sel3_reg[u] <= PT_START;
                else if (wb2_reg[u] >= bb2_reg[u])
                    sel3_reg[u] <= PT_END;
                else
                    sel3_reg[u] <= PT_MID;
                ww3_reg[u] <= ww2_reg[u][CRS_W-1:0];
                ee3_reg[u] <= ee2_reg[u][CRS_W-1:0];
                bb3_reg[u] <= bb2_reg[u][CRS_W-1:0];
                for (int i = 0; i < 3; i++)
                begin
                    m = mag_crs(xsel(c2_reg[u], 2'(i)));
                    chh3_reg[u][i] <= m[CRS_W-1:CRS_HALF] * m[CRS_W-1:CRS_HALF];
                    chl3_reg[u][i] <= m[CRS_W-1:CRS_HALF] * m[CRS_HALF-1:0];
                    cll3_reg[u][i] <= m[CRS_HALF-1:0] * m[CRS_HALF-1:0];
                end
            end

            op3_reg[0]  <= OP_W'(ibb2_reg);
            op3_reg[1]  <= OP_W'(iar2_reg);
            op3_reg[2]  <= OP_W'(iab2_reg);
            op3_reg[3]  <= OP_W'(ibr2_reg);
            op3_reg[4]  <= OP_W'(iab2_reg);
            op3_reg[5]  <= OP_W'(ibr2_reg) + OP_W'(iab2_reg);
            op3_reg[6]  <= OP_W'(ibb2_reg);
            op3_reg[7]  <= OP_W'(iar2_reg) + OP_W'(iaa2_reg);
            op3_reg[8]  <= OP_W'(iab2_reg);
            op3_reg[9]  <= OP_W'(iar2_reg);
            op3_reg[10] <= OP_W'(iaa2_reg);
            op3_reg[11] <= OP_W'(ibr2_reg);
            op3_reg[12] <= OP_W'(iaa2_reg);
            op3_reg[13] <= OP_W'(ibr2_reg) - OP_W'(ibb2_reg);
            op3_reg[14] <= OP_W'(iab2_reg);
            op3_reg[15] <= OP_W'(iar2_reg) - OP_W'(iab2_reg);

            nz3_reg <= (n2_reg != '0);
            for (int i = 0; i < 3; i++)
            begin
                nc = xsel(n2_reg, 2'(i));
                m  = mag_crs(nc);
                nhh3_reg[i] <= m[CRS_W-1:CRS_HALF] * m[CRS_W-1:CRS_HALF];
                nhl3_reg[i] <= m[CRS_W-1:CRS_HALF] * m[CRS_HALF-1:0];
                nll3_reg[i] <= m[CRS_HALF-1:0] * m[CRS_HALF-1:0];
                rnh3_reg[i] <= dsel(r2_reg, 2'(i)) * $signed(nc[CRS_W-1:CRS_HALF]);
                rnl3_reg[i] <= dsel(r2_reg, 2'(i)) * $signed({1'b0, nc[CRS_HALF-1:0]});
            end
        end
    end

    // stage 4: candidate ratios, interior product partials
    always_ff @(posedge clk)
    begin
        logic [DEN_W-1:0]       acc;
        logic [DEN_W-1:0]       nacc;
        logic signed [RN_W-1:0] racc;
        logic [OP_W-1:0]        mp;
        logic [OP_W-1:0]        mq;
        if (advance)
        begin
            for (int u = 0; u < N_PT; u++)
            begin
                acc = '0;
                for (int i = 0; i < 3; i++)
                begin
                    acc = acc + (DEN_W'(chh3_reg[u][i]) << (2 * CRS_HALF))
                              + (DEN_W'(chl3_reg[u][i]) << (CRS_HALF + 1))
                              + DEN_W'(cll3_reg[u][i]);
                end
                case (sel3_reg[u])
                    PT_START:
                    begin
                        pn4_reg[u] <= NUM_W'(ww3_reg[u]);
                        pm4_reg[u] <= DEN_W'(1);
                    end
                    PT_END:
                    begin
                        pn4_reg[u] <= NUM_W'(ee3_reg[u]);
                        pm4_reg[u] <= DEN_W'(1);
                    end
                    default:
                    begin
                        pn4_reg[u] <= NUM_W'(acc);
                        pm4_reg[u] <= DEN_W'(bb3_reg[u]);
                    end
                endcase
            end

            for (int t = 0; t < N_PROD; t++)
            begin
                mp = mag_op(op3_reg[2*t]);
                mq = mag_op(op3_reg[2*t+1]);
                qhh4_reg[t]  <= mp[OP_W-1:OP_HALF] * mq[OP_W-1:OP_HALF];
                qhl4_reg[t]  <= mp[OP_W-1:OP_HALF] * mq[OP_HALF-1:0];
                qlh4_reg[t]  <= mp[OP_HALF-1:0] * mq[OP_W-1:OP_HALF];
                qll4_reg[t]  <= mp[OP_HALF-1:0] * mq[OP_HALF-1:0];
                qneg4_reg[t] <= op3_reg[2*t][OP_W-1] ^ op3_reg[2*t+1][OP_W-1];
            end

            nacc = '0;
            racc = '0;
            for (int i = 0; i < 3; i++)
            begin
                nacc = nacc + (DEN_W'(nhh3_reg[i]) << (2 * CRS_HALF))
                            + (DEN_W'(nhl3_reg[i]) << (CRS_HALF + 1))
                            + DEN_W'(nll3_reg[i]);
                racc = racc + (RN_W'(rnh3_reg[i]) <<< CRS_HALF) + RN_W'(rnl3_reg[i]);
            end
            nz4_reg <= nz3_reg;
            im4_reg <= nacc;
            rn4_reg <= racc;
        end
    end

    // stage 5: signed products, square partials of r.n
    always_ff @(posedge clk)
    begin
        logic [PROD_W-1:0]   m;
        logic [RN_W-1:0]     rm;
        if (advance)
        begin
            pn5_reg <= pn4_reg;
            pm5_reg <= pm4_reg;
            for (int t = 0; t < N_PROD; t++)
            begin
                m = (PROD_W'(qhh4_reg[t]) << (2 * OP_HALF))
                  + ((PROD_W'(qhl4_reg[t]) + PROD_W'(qlh4_reg[t])) << OP_HALF)
                  + PROD_W'(qll4_reg[t]);
                prod5_reg[t] <= qneg4_reg[t] ? $signed(~m + PROD_W'(1)) : $signed(m);
            end
            rm = mag_rn(rn4_reg);
            rhh5_reg <= rm[RN_MAG_W-1:RN_HALF] * rm[RN_MAG_W-1:RN_HALF];
            rhl5_reg <= rm[RN_MAG_W-1:RN_HALF] * rm[RN_HALF-1:0];
            rll5_reg <= rm[RN_HALF-1:0] * rm[RN_HALF-1:0];
            nz5_reg  <= nz4_reg;
            im5_reg  <= im4_reg;
        end
    end

    // stage 6: interior range test and numerator
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pn6_reg <= pn5_reg;
            pm6_reg <= pm5_reg;
            ok6_reg <= nz5_reg
                    && (prod5_reg[0] <= prod5_reg[1])
                    && (prod5_reg[2] <= prod5_reg[3])
                    && (prod5_reg[4] <= prod5_reg[5])
                    && (prod5_reg[6] <= prod5_reg[7]);
            im6_reg <= im5_reg;
            in6_reg <= (NUM_W'(rhh5_reg) << (2 * RN_HALF))
                     + (NUM_W'(rhl5_reg) << (RN_HALF + 1))
                     + NUM_W'(rll5_reg);
        end
    end

    for (genvar u = 0; u < N_PT; u++) begin : g_pt_root
        ssd3_root u_root (
            .clk  (clk),
            .en   (advance),
            .num  (pn6_reg[u]),
            .den  (pm6_reg[u]),
            .root (rt[u])
        );
    end

    ssd3_root u_int_root (
        .clk  (clk),
        .en   (advance),
        .num  (in6_reg),
        .den  (im6_reg),
        .root (rt[N_PT])
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            okp_reg <= {okp_reg[ROOT_STAGES-2:0], ok6_reg};
        end
    end

    always_comb
    begin
        best = rt[0];
        for (int u = 1; u < N_PT; u++)
        begin
            if (rt[u] < best)
                best = rt[u];
        end
        if (okp_reg[ROOT_STAGES-1] && rt[N_PT] < best)
            best = rt[N_PT];
        if (best > DIST_CAP)
            best = DIST_CAP;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dist_reg <= best;
        end
    end

    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign distance  = dist_reg;

endmodule

>>> rtl/ssd3_root.sv
// ----------------------------------------------------------------------------
// ssd3_root
// Pipelined root of a ratio: largest r below 2^DIST_W with r*r*den <= num,
// one result bit per stage, no multipliers.
// ----------------------------------------------------------------------------
module ssd3_root (
    input  logic                       clk,
    input  logic                       en,
    input  logic [ssd3_pkg::NUM_W-1:0] num,
    input  logic [ssd3_pkg::DEN_W-1:0] den,
    output logic [ssd3_pkg::DIST_W-1:0] root
);
    import ssd3_pkg::*;

    logic [NUM_W-1:0]  num_reg [ROOT_STAGES-1];
    logic [DEN_W-1:0]  den_reg [ROOT_STAGES-1];
    logic [SQ_W-1:0]   sq_reg  [ROOT_STAGES];
    logic [RM_W-1:0]   rm_reg  [ROOT_STAGES];
    logic [DIST_W-1:0] r_reg   [ROOT_STAGES];

    for (genvar j = 0; j < ROOT_STAGES; j++) begin : g_stage
        localparam int B = ROOT_STAGES - 1 - j;
        logic [NUM_W-1:0]  num_in;
        logic [DEN_W-1:0]  den_in;
        logic [SQ_W-1:0]   sq_in;
        logic [RM_W-1:0]   rm_in;
        logic [DIST_W-1:0] r_in;
        logic [SQ_W-1:0]   sq_next;
        logic              take;

        if (j == 0) begin : g_first
            assign num_in = num;
            assign den_in = den;
            assign sq_in  = '0;
            assign rm_in  = '0;
            assign r_in   = '0;
        end
        else begin : g_rest
            assign num_in = num_reg[j-1];
            assign den_in = den_reg[j-1];
            assign sq_in  = sq_reg[j-1];
            assign rm_in  = rm_reg[j-1];
            assign r_in   = r_reg[j-1];
        end

        // (r + 2^B)^2 * den = r^2*den + 2^(B+1)*r*den + 2^(2B)*den
        assign sq_next = sq_in + (SQ_W'(rm_in) << (B + 1)) + (SQ_W'(den_in) << (2 * B));
        assign take    = (sq_next <= SQ_W'(num_in));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (take)
                begin
                    sq_reg[j] <= sq_next;
                    rm_reg[j] <= rm_in + (RM_W'(den_in) << B);
                    r_reg[j]  <= r_in | (DIST_W'(1) << B);
                end
                else
                begin
                    sq_reg[j] <= sq_in;
                    rm_reg[j] <= rm_in;
                    r_reg[j]  <= r_in;
                end
            end
        end

        if (j < ROOT_STAGES - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[j] <= num_in;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign root = r_reg[ROOT_STAGES-1];

endmodule
